// File: rtl/tksd_pkg.sv
// Package for the terminal key sequence decoder: parser states, event kinds,
// key codes, byte constants and the state and result structs.
// No dependencies.
package tksd_pkg;

    typedef enum logic [12:0] {
        ST_GROUND = 13'b0000000000001,
        ST_UTF    = 13'b0000000000010,
        ST_DROP   = 13'b0000000000100,
        ST_ESC    = 13'b0000000001000,
        ST_ESC_O  = 13'b0000000010000,
        ST_CSI    = 13'b0000000100000,
        ST_CSI1   = 13'b0000001000000,
        ST_MOD    = 13'b0000010000000,
        ST_CSI2   = 13'b0000100000000,
        ST_CSI3   = 13'b0001000000000,
        ST_TILDE  = 13'b0010000000000,
        ST_IAC    = 13'b0100000000000,
        ST_OPT    = 13'b1000000000000
    } parse_state_t;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_CTRL  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [7:0] K_UP    = 8'h80;
    localparam logic [7:0] K_HOME  = 8'h84;
    localparam logic [7:0] K_END   = 8'h85;
    localparam logic [7:0] K_PGUP  = 8'h86;
    localparam logic [7:0] K_PGDN  = 8'h87;
    localparam logic [7:0] K_INS   = 8'h88;
    localparam logic [7:0] K_DEL   = 8'h89;
    localparam logic [7:0] K_BTAB  = 8'h8A;
    localparam logic [7:0] K_F0    = 8'h90;

    localparam logic [7:0] BYTE_EOT    = 8'h04;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_ESC    = 8'h1B;
    localparam logic [7:0] BYTE_SEMI   = 8'h3B;
    localparam logic [7:0] BYTE_O      = 8'h4F;
    localparam logic [7:0] BYTE_LBRACK = 8'h5B;
    localparam logic [7:0] BYTE_TILDE  = 8'h7E;
    localparam logic [7:0] BYTE_IAC    = 8'hFF;

    localparam logic [20:0] CP_MAX = 21'h10FFFF;

    localparam logic [2:0] MOD_ALT  = 3'b010;
    localparam logic [2:0] MOD_CTRL = 3'b100;

    typedef struct packed {
        parse_state_t parse_state;
        parse_state_t return_state;
        logic [2:0]   utf_expected;
        logic [2:0]   utf_received;
        logic [20:0]  utf_accum;
        logic [2:0]   mod_flags;
    } dec_state_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  event_kind;
        logic [20:0] code_point;
        logic [7:0]  ctrl_code;
        logic [2:0]  mods;
    } dec_result_t;

endpackage

// File: rtl/tksd_step.sv
// One parser step of the terminal key sequence decoder: next state and
// optional result for one byte. Depends on tksd_pkg.
module tksd_step (
    input  logic [7:0]           in_byte,
    input  tksd_pkg::dec_state_t cur,
    output tksd_pkg::dec_state_t nxt,
    output tksd_pkg::dec_result_t res
);

    logic [20:0] acc_shift;
    logic [2:0]  rcv_inc;

    assign acc_shift = {cur.utf_accum[14:0], in_byte[5:0]};
    assign rcv_inc   = cur.utf_received + 3'd1;

    always_comb
    begin
        nxt = cur;
        res = '0;
        unique case (cur.parse_state)
            tksd_pkg::ST_GROUND:
            begin
                nxt.mod_flags = '0;
                priority if (in_byte == tksd_pkg::BYTE_IAC)
                begin
                    nxt.parse_state = tksd_pkg::ST_IAC;
                end
                else if (in_byte == tksd_pkg::BYTE_ESC)
                begin
                    nxt.parse_state = tksd_pkg::ST_ESC;
                end
                else if (in_byte == tksd_pkg::BYTE_EOT)
                begin
                    res.valid      = 1'b1;
                    res.event_kind = tksd_pkg::KIND_END;
                end
                else if (in_byte == tksd_pkg::BYTE_CR)
                begin
                    nxt.parse_state = tksd_pkg::ST_DROP;
                    res.valid       = 1'b1;
                    res.event_kind  = tksd_pkg::KIND_CTRL;
                    res.ctrl_code   = in_byte;
                end
                else if (in_byte[7])
                begin
                    nxt.utf_received = 3'd1;
                    nxt.parse_state  = tksd_pkg::ST_UTF;
                    priority if (in_byte[7:5] == 3'b110)
                    begin
                        nxt.utf_expected = 3'd2;
                        nxt.utf_accum    = {16'd0, in_byte[4:0]};
                    end
                    else if (in_byte[7:4] == 4'b1110)
                    begin
                        nxt.utf_expected = 3'd3;
                        nxt.utf_accum    = {17'd0, in_byte[3:0]};
                    end
                    else if (in_byte[7:3] == 5'b11110)
                    begin
                        nxt.utf_expected = 3'd4;
                        nxt.utf_accum    = {18'd0, in_byte[2:0]};
                    end
                    else
                    begin
                        nxt.utf_received = cur.utf_received;
                        nxt.parse_state  = tksd_pkg::ST_GROUND;
                        res.valid        = 1'b1;
                        res.event_kind   = tksd_pkg::KIND_ERROR;
                    end
                end
                else if (in_byte >= 8'h20 && in_byte <= 8'h7E)
                begin
                    res.valid      = 1'b1;
                    res.event_kind = tksd_pkg::KIND_CHAR;
                    res.code_point = {13'd0, in_byte};
                end
                else
                begin
                    res.valid      = 1'b1;
                    res.event_kind = tksd_pkg::KIND_CTRL;
                    res.ctrl_code  = in_byte;
                end
            end
            tksd_pkg::ST_UTF:
            begin
                res.valid = 1'b1;
                if (in_byte[7:6] != 2'b10)
                begin
                    nxt.parse_state = tksd_pkg::ST_GROUND;
                    res.event_kind  = tksd_pkg::KIND_ERROR;
                end
                else
                begin
                    nxt.utf_accum    = acc_shift;
                    nxt.utf_received = rcv_inc;
                    if (rcv_inc < cur.utf_expected)
                    begin
                        res.valid = 1'b0;
                    end
                    else
                    begin
                        nxt.parse_state = tksd_pkg::ST_GROUND;
                        if (acc_shift > tksd_pkg::CP_MAX)
                        begin
                            res.event_kind = tksd_pkg::KIND_ERROR;
                        end
                        else
                        begin
                            res.event_kind = tksd_pkg::KIND_CHAR;
                            res.code_point = acc_shift;
                        end
                    end
                end
            end
            tksd_pkg::ST_ESC:
            begin
                res.valid = 1'b1;
                priority if (in_byte == tksd_pkg::BYTE_ESC)
                begin
                    res.event_kind = tksd_pkg::KIND_CTRL;
                    res.ctrl_code  = in_byte;
                end
                else if (in_byte == tksd_pkg::BYTE_LBRACK)
                begin
                    nxt.parse_state = tksd_pkg::ST_CSI;
                    res.valid       = 1'b0;
                end
                else if (in_byte == tksd_pkg::BYTE_O)
                begin
                    nxt.parse_state = tksd_pkg::ST_ESC_O;
                    res.valid       = 1'b0;
                end
                else if (in_byte >= 8'h20 && in_byte <= 8'h7E)
                begin
                    nxt.parse_state = tksd_pkg::ST_GROUND;
                    res.event_kind  = tksd_pkg::KIND_CHAR;
                    res.code_point  = {13'd0, in_byte};
                    res.mods        = tksd_pkg::MOD_ALT;
                end
                else
                begin
                    nxt.parse_state = tksd_pkg::ST_GROUND;
                    res.event_kind  = tksd_pkg::KIND_ERROR;
                end
            end
            tksd_pkg::ST_ESC_O:
            begin
                res.valid       = 1'b1;
                nxt.parse_state = tksd_pkg::ST_GROUND;
                if (in_byte >= 8'h41 && in_byte <= 8'h44)
                begin
                    nxt.mod_flags  = cur.mod_flags | tksd_pkg::MOD_CTRL;
                    res.event_kind = tksd_pkg::KIND_CTRL;
                    res.ctrl_code  = tksd_pkg::K_UP + (in_byte - 8'h41);
                    res.mods       = cur.mod_flags | tksd_pkg::MOD_CTRL;
                end
                else
                begin
                    res.event_kind = tksd_pkg::KIND_ERROR;
                end
            end
            tksd_pkg::ST_CSI:
            begin
                res.valid       = 1'b1;
                res.event_kind  = tksd_pkg::KIND_CTRL;
                nxt.parse_state = tksd_pkg::ST_GROUND;
                res.mods        = cur.mod_flags;
                unique case (in_byte)
                    8'h41, 8'h42, 8'h43, 8'h44:
                        res.ctrl_code = tksd_pkg::K_UP + (in_byte - 8'h41);
                    8'h46: res.ctrl_code = tksd_pkg::K_END;
                    8'h48: res.ctrl_code = tksd_pkg::K_HOME;
                    8'h5A: res.ctrl_code = tksd_pkg::K_BTAB;
                    8'h31:
                    begin
                        nxt.parse_state = tksd_pkg::ST_CSI1;
                        res             = '0;
                    end
                    8'h32:
                    begin
                        nxt.parse_state = tksd_pkg::ST_CSI2;
                        res             = '0;
                    end
                    8'h33:
                    begin
                        nxt.parse_state = tksd_pkg::ST_CSI3;
                        res             = '0;
                    end
                    8'h34, 8'h38:
                    begin
                        nxt.parse_state = tksd_pkg::ST_TILDE;
                        res.ctrl_code   = tksd_pkg::K_END;
                        res.mods        = '0;
                    end
                    8'h35:
                    begin
                        nxt.parse_state = tksd_pkg::ST_TILDE;
                        res.ctrl_code   = tksd_pkg::K_PGUP;
                        res.mods        = '0;
                    end
                    8'h36:
                    begin
                        nxt.parse_state = tksd_pkg::ST_TILDE;
                        res.ctrl_code   = tksd_pkg::K_PGDN;
                        res.mods        = '0;
                    end
                    8'h37:
                    begin
                        nxt.parse_state = tksd_pkg::ST_TILDE;
                        res.ctrl_code   = tksd_pkg::K_HOME;
                        res.mods        = '0;
                    end
                    default:
                    begin
                        res.event_kind = tksd_pkg::KIND_ERROR;
                        res.mods       = '0;
                    end
                endcase
            end
            tksd_pkg::ST_CSI1:
            begin
                res.valid       = 1'b1;
                res.event_kind  = tksd_pkg::KIND_CTRL;
                nxt.parse_state = tksd_pkg::ST_TILDE;
                priority if (in_byte == tksd_pkg::BYTE_TILDE)
                begin
                    nxt.parse_state = tksd_pkg::ST_GROUND;
                    res.ctrl_code   = tksd_pkg::K_HOME;
                    res.mods        = cur.mod_flags;
                end
                else if (in_byte == tksd_pkg::BYTE_SEMI)
                begin
                    nxt.parse_state  = tksd_pkg::ST_MOD;
                    nxt.return_state = tksd_pkg::ST_CSI;
                    res.valid        = 1'b0;
                    res.event_kind   = tksd_pkg::KIND_CHAR;
                end
                else if (in_byte >= 8'h30 && in_byte <= 8'h35)
                begin
                    res.ctrl_code = tksd_pkg::K_F0 + (in_byte - 8'h30);
                end
                else if (in_byte >= 8'h37 && in_byte <= 8'h39)
                begin
                    res.ctrl_code = tksd_pkg::K_F0 + 8'd6 + (in_byte - 8'h37);
                end
                else if (in_byte >= 8'h50 && in_byte <= 8'h53)
                begin
                    nxt.parse_state = tksd_pkg::ST_GROUND;
                    res.ctrl_code   = tksd_pkg::K_F0 + 8'd1 + (in_byte - 8'h50);
                end
                else
                begin
                    nxt.parse_state = tksd_pkg::ST_GROUND;
                    res.event_kind  = tksd_pkg::KIND_ERROR;
                end
            end
            tksd_pkg::ST_MOD:
            begin
                nxt.mod_flags   = cur.mod_flags | (in_byte[2:0] - 3'd1);
                nxt.parse_state = cur.return_state;
            end
            tksd_pkg::ST_CSI2:
            begin
                res.valid       = 1'b1;
                res.event_kind  = tksd_pkg::KIND_CTRL;
                nxt.parse_state = tksd_pkg::ST_TILDE;
                priority if (in_byte == tksd_pkg::BYTE_TILDE)
                begin
                    nxt.parse_state = tksd_pkg::ST_GROUND;
                    res.ctrl_code   = tksd_pkg::K_INS;
                    res.mods        = cur.mod_flags;
                end
                else if (in_byte == tksd_pkg::BYTE_SEMI)
                begin
                    nxt.parse_state  = tksd_pkg::ST_MOD;
                    nxt.return_state = tksd_pkg::ST_CSI2;
                    res.valid        = 1'b0;
                    res.event_kind   = tksd_pkg::KIND_CHAR;
                end
                else if (in_byte >= 8'h30 && in_byte <= 8'h31)
                begin
                    res.ctrl_code = tksd_pkg::K_F0 + 8'd9 + (in_byte - 8'h30);
                end
                else if (in_byte >= 8'h33 && in_byte <= 8'h36)
                begin
                    res.ctrl_code = tksd_pkg::K_F0 + 8'd11 + (in_byte - 8'h33);
                end
                else if (in_byte >= 8'h38 && in_byte <= 8'h39)
                begin
                    res.ctrl_code = tksd_pkg::K_F0 + 8'd15 + (in_byte - 8'h38);
                end
                else
                begin
                    nxt.parse_state = tksd_pkg::ST_GROUND;
                    res.event_kind  = tksd_pkg::KIND_ERROR;
                end
            end
            tksd_pkg::ST_CSI3:
            begin
                res.valid       = 1'b1;
                res.event_kind  = tksd_pkg::KIND_CTRL;
                nxt.parse_state = tksd_pkg::ST_TILDE;
                priority if (in_byte == tksd_pkg::BYTE_TILDE)
                begin
                    nxt.parse_state = tksd_pkg::ST_GROUND;
                    res.ctrl_code   = tksd_pkg::K_DEL;
                    res.mods        = cur.mod_flags;
                end
                else if (in_byte == tksd_pkg::BYTE_SEMI)
                begin
                    nxt.parse_state  = tksd_pkg::ST_MOD;
                    nxt.return_state = tksd_pkg::ST_CSI3;
                    res.valid        = 1'b0;
                    res.event_kind   = tksd_pkg::KIND_CHAR;
                end
                else if (in_byte >= 8'h31 && in_byte <= 8'h34)
                begin
                    res.ctrl_code = tksd_pkg::K_F0 + 8'd17 + (in_byte - 8'h31);
                end
                else
                begin
                    nxt.parse_state = tksd_pkg::ST_GROUND;
                    res.event_kind  = tksd_pkg::KIND_ERROR;
                end
            end
            tksd_pkg::ST_TILDE:
            begin
                nxt.parse_state = tksd_pkg::ST_GROUND;
                if (in_byte != tksd_pkg::BYTE_TILDE)
                begin
                    res.valid      = 1'b1;
                    res.event_kind = tksd_pkg::KIND_ERROR;
                end
            end
            tksd_pkg::ST_IAC:
            begin
                if (in_byte >= 8'hFB && in_byte <= 8'hFE)
                begin
                    nxt.parse_state = tksd_pkg::ST_OPT;
                end
                else
                begin
                    nxt.parse_state = tksd_pkg::ST_GROUND;
                    res.valid       = 1'b1;
                    res.event_kind  = tksd_pkg::KIND_ERROR;
                end
            end
            default:
            begin
                nxt.parse_state = tksd_pkg::ST_GROUND;
            end
        endcase
    end

endmodule

// File: rtl/terminal_key_sequence_decoder_top.sv
// Top level of the terminal key sequence decoder: input register, parser
// state registers and result register. Depends on tksd_pkg and tksd_step.
//
// Usage: terminal bytes enter on the s_axis channel, one byte per item.
// Each byte yields zero or one key event on the m_axis channel: tuser holds
// the event kind, tdata the code point, control code and modifier flags.
// A byte accepted into the input register sits there while the parser step
// works on it; its event is loaded into the result register when the step
// fires. Throughput: one byte per cycle while the receiver does not stall,
// set by the combinational parser step between the two registers.
// Reset clears the parser to ground, empties both registers and clears the
// modifier and UTF-8 state.
// When the receiver stalls, the event waits in the result register and the
// byte in the input register waits behind it, whether or not it yields an
// event; s_axis_tready drops only while the input register is full and
// cannot advance.
module terminal_key_sequence_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [20:0] code_point, [28:21] ctrl_code,
                                        // [29] mod_shift, [30] mod_alt, [31] mod_ctrl
    output logic [1:0]  m_axis_tuser    // [1:0] event_kind
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [7:0]            in_byte_reg;
    tksd_pkg::dec_state_t  state_reg;
    tksd_pkg::dec_state_t  state_next;
    tksd_pkg::dec_result_t step_res;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [31:0]           out_data_reg;
    logic [1:0]            out_kind_reg;
    logic                  fire;
    logic                  in_take;

    tksd_step u_step (
        .in_byte (in_byte_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (step_res)
    );

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = step_res.valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            state_reg.parse_state  <= tksd_pkg::ST_GROUND;
            state_reg.return_state <= tksd_pkg::ST_GROUND;
            state_reg.utf_expected <= '0;
            state_reg.utf_received <= '0;
            state_reg.utf_accum    <= '0;
            state_reg.mod_flags    <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (fire && step_res.valid)
        begin
            out_data_reg <= {step_res.mods[2], step_res.mods[1], step_res.mods[0],
                             step_res.ctrl_code, step_res.code_point};
            out_kind_reg <= step_res.event_kind;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_byte_reg))
        else $error("waiting input byte lost or changed");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(m_axis_tready))
        else $error("result dropped while receiver stalled");

    a_utf_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.parse_state == tksd_pkg::ST_UTF |->
            state_reg.utf_received < state_reg.utf_expected &&
            state_reg.utf_expected >= 3'd2)
        else $error("UTF-8 counters out of range");

    a_mod_return: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.parse_state == tksd_pkg::ST_MOD |->
            state_reg.return_state == tksd_pkg::ST_CSI ||
            state_reg.return_state == tksd_pkg::ST_CSI2 ||
            state_reg.return_state == tksd_pkg::ST_CSI3)
        else $error("modifier state with bad return state");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == tksd_pkg::KIND_ERROR ||
            m_axis_tuser == tksd_pkg::KIND_END) |-> m_axis_tdata == 32'd0)
        else $error("error or session end item carries payload");

endmodule
